@@ hdl/ibal_pkg.sv @@
// Shared types and constants for the bitmap identifier allocator.
package ibal_pkg;

  localparam int MAP_WORDS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;
  localparam int ID_W          = 8;
  localparam int ID_SPACE      = 256;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_MARK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_MOD  = 1'b1
  } state_t;

endpackage

@@ hdl/ibal_map_mem.sv @@
// Used-map word memory with one read and one write port and per-entry valid bits.
module ibal_map_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_q_r;
  logic             rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // An entry never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : '0;

endmodule

@@ hdl/ibal_bit_scan.sv @@
// Finds the lowest clear bit of a used-map word.
module ibal_bit_scan #(
  parameter int WIDTH = 32,
  parameter int COL_W = 5
) (
  input  logic [WIDTH-1:0] word,
  output logic             any_zero,
  output logic [COL_W-1:0] col
);

  always_comb begin
    any_zero = 1'b0;
    col      = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      if (!word[i]) begin
        any_zero = 1'b1;
        col      = COL_W'(i);
      end
    end
  end

endmodule

@@ hdl/id_bitmap_allocator_core.sv @@
// First-fit identifier allocator over a used-map held in a synchronous memory.
// The used-map word is read at the input transfer edge, then modified and written back
// at the edge that raises out_valid, from the ST_MOD state.
// A new request is not taken until the previous one is written back (in_ready only in ST_IDLE).
// A result waiting on out_ready holds the ST_MOD state until the output register frees.
// Reset clears the per-word full flags and the memory valid bits at once; no clearing pass.
module id_bitmap_allocator_core
  import ibal_pkg::*;
#(
  parameter int MAP_WORDS = MAP_WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_mode,
  input  logic [ID_W-1:0] in_ident,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] out_granted_ident,
  output logic            out_success
);

  localparam int ROW_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int COL_W = $clog2(WORD_BITS);
  localparam int SUM_W = (ROW_W + COL_W + 1 > ID_W + 1) ? ROW_W + COL_W + 1 : ID_W + 1;

  state_t state_r, state_nxt;

  logic [MAP_WORDS-1:0] full_r;
  mode_t                mode_r;
  logic [ROW_W-1:0]     row_r;
  logic [COL_W-1:0]     col_r;
  logic                 act_r;

  logic                 out_valid_r;
  logic [ID_W-1:0]      out_granted_ident_r;
  logic                 out_success_r;

  logic                 in_xfer;
  logic                 mod_go;
  logic [ROW_W-1:0]     ident_row;
  logic [ID_W-1:0]      ident_base;
  logic [COL_W-1:0]     ident_col;
  logic                 ident_in_range;
  logic [ROW_W-1:0]     alloc_row;
  logic                 alloc_found;
  logic [ROW_W-1:0]     req_row;
  logic                 req_act;

  logic [WORD_BITS-1:0] rd_word;
  logic                 scan_any;
  logic [COL_W-1:0]     scan_col;
  logic [SUM_W-1:0]     alloc_id;
  logic                 alloc_ok;
  logic [COL_W-1:0]     upd_col;
  logic [WORD_BITS-1:0] upd_bit;
  logic [WORD_BITS-1:0] new_word;
  logic                 wr_en;
  logic [ID_W-1:0]      res_ident;
  logic                 res_success;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  // Row of the named identifier: count the word boundaries at or below it.
  always_comb begin
    ident_row = '0;
    for (int k = 1; k < MAP_WORDS; k++) begin
      if (int'(in_ident) >= k * WORD_BITS) begin
        ident_row = ROW_W'(k);
      end
    end
    ident_base     = ID_W'(ident_row * WORD_BITS);
    ident_col      = COL_W'(in_ident - ident_base);
    ident_in_range = int'(in_ident) < MAP_WORDS * WORD_BITS;
  end

  // Lowest word that is not full, among words that start below the id space limit.
  always_comb begin
    alloc_row   = '0;
    alloc_found = 1'b0;
    for (int k = MAP_WORDS - 1; k >= 0; k--) begin
      if ((k * WORD_BITS < ID_SPACE) && !full_r[k]) begin
        alloc_row   = ROW_W'(k);
        alloc_found = 1'b1;
      end
    end
  end

  always_comb begin
    req_row = ident_row;
    req_act = 1'b0;
    case (mode_t'(in_mode))
      MODE_ALLOC: begin
        req_row = alloc_row;
        req_act = alloc_found;
      end
      MODE_FREE,
      MODE_MARK: req_act = ident_in_range;
      default:   req_act = 1'b0;
    endcase
  end

  ibal_map_mem #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .ADDR_W(ROW_W)
  ) u_map_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_xfer),
    .rd_addr(req_row),
    .rd_data(rd_word),
    .wr_en  (wr_en),
    .wr_addr(row_r),
    .wr_data(new_word)
  );

  ibal_bit_scan #(
    .WIDTH(WORD_BITS),
    .COL_W(COL_W)
  ) u_bit_scan (
    .word    (rd_word),
    .any_zero(scan_any),
    .col     (scan_col)
  );

  // A word that straddles the id space limit can still fail on its lowest free bit.
  assign alloc_id = SUM_W'(row_r * WORD_BITS) + SUM_W'(scan_col);
  assign alloc_ok = act_r && scan_any && (alloc_id < SUM_W'(ID_SPACE));

  always_comb begin
    upd_col     = col_r;
    new_word    = rd_word;
    res_ident   = '0;
    res_success = 1'b1;
    wr_en       = 1'b0;
    mod_go      = (state_r == ST_MOD) && (!out_valid_r || out_ready);
    case (mode_r)
      MODE_ALLOC: begin
        upd_col     = scan_col;
        res_success = alloc_ok;
        res_ident   = alloc_ok ? ID_W'(alloc_id) : '0;
        wr_en       = mod_go && alloc_ok;
      end
      MODE_FREE,
      MODE_MARK: wr_en = mod_go && act_r;
      default:   wr_en = 1'b0;
    endcase
    upd_bit = WORD_BITS'(1) << upd_col;
    if (mode_r == MODE_FREE) begin
      new_word = rd_word & ~upd_bit;
    end else begin
      new_word = rd_word | upd_bit;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_MOD;
      ST_MOD:  if (mod_go)  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mode_r <= mode_t'(in_mode);
      row_r  <= req_row;
      col_r  <= ident_col;
      act_r  <= req_act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= '0;
    end else if (wr_en) begin
      full_r[row_r] <= &new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mod_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_go) begin
      out_granted_ident_r <= res_ident;
      out_success_r       <= res_success;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_granted_ident = out_granted_ident_r;
  assign out_success       = out_success_r;

endmodule
